[rtl/ztd_pkg.sv]
// Shared constants, register codes and types of the zero crossing tone detector.
package ztd_pkg;

   // Sample path sizing.
   localparam int SAMPLE_BITS   = 10;
   localparam int WINDOW_DEPTH  = 64;
   localparam int POS_BITS      = $clog2(WINDOW_DEPTH);
   localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int CENTERED_BITS = SAMPLE_BITS + 1;

   // Period and count sizing.
   localparam int PERIOD_BITS = 16;
   localparam logic [PERIOD_BITS-1:0] PERIOD_SAT = '1;
   localparam int COUNT_BITS = 5;
   localparam int TIME_BITS  = 32;

   // Register port sizing.
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // Register values after reset.
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN_RESET   = PERIOD_BITS'(7);
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX_RESET   = PERIOD_BITS'(9);
   localparam logic [COUNT_BITS-1:0]  COUNT_TARGET_RESET = COUNT_BITS'(5);
   localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT_RESET  = COUNT_BITS'(20);
   localparam logic [TIME_BITS-1:0]   HOLDOFF_RESET      = TIME_BITS'(1000);

   // Register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PERIOD_MIN   = 3'd0,
      CSR_PERIOD_MAX   = 3'd1,
      CSR_COUNT_TARGET = 3'd2,
      CSR_COUNT_LIMIT  = 3'd3,
      CSR_HOLDOFF_TIME = 3'd4
   } csr_index_type;

   // Configuration as seen by the detection stage.
   typedef struct packed {
      logic [PERIOD_BITS-1:0] period_min;
      logic [PERIOD_BITS-1:0] period_max;
      logic [COUNT_BITS-1:0]  count_target;
      logic [COUNT_BITS-1:0]  count_limit;
      logic [TIME_BITS-1:0]   holdoff_time;
   } ztd_cfg_type;

   // One result beat.
   typedef struct packed {
      logic signed [CENTERED_BITS-1:0] centered;
      logic                            crossing;
      logic [PERIOD_BITS-1:0]          period;
      logic [COUNT_BITS-1:0]           valid_count;
      logic                            detected;
   } ztd_result_type;

endpackage

[rtl/ztd_ram.sv]
// Generic single write port RAM with one registered read port.
module ztd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ztd_detect.sv]
// Crossing detection, period measurement and valid period counting stage.
module ztd_detect (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic signed [ztd_pkg::CENTERED_BITS-1:0] centered,
   input  logic [ztd_pkg::TIME_BITS-1:0]            timestamp,
   input  ztd_pkg::ztd_cfg_type                     cfg,
   output ztd_pkg::ztd_result_type                  result
);

   import ztd_pkg::*;

   logic signed [CENTERED_BITS-1:0] prev_centered_ff;
   logic [PERIOD_BITS-1:0]          since_ff, since_in, since_inc;
   logic [COUNT_BITS-1:0]           good_ff, good_in, good_clamped;
   logic [TIME_BITS-1:0]            last_hit_ff, last_hit_in, deadline;
   logic [COUNT_BITS:0]             count_up;
   logic                            crossing, in_window, reach, expired, detected;
   logic [PERIOD_BITS-1:0]          period;

   // Saturating sample count since the previous rising crossing.
   assign since_inc = (since_ff == PERIOD_SAT) ? since_ff : since_ff + 1'b1;

   // Rising crossing: previous value below zero, current above zero.
   assign crossing = (prev_centered_ff < 0) && (centered > 0);

   assign in_window = (since_inc >= cfg.period_min) && (since_inc <= cfg.period_max);

   // Raised count is compared to the target before it is clamped.
   assign count_up     = {1'b0, good_ff} + 1'b1;
   assign reach        = (count_up == {1'b0, cfg.count_target});
   assign good_clamped = (count_up > {1'b0, cfg.count_limit}) ?
                         cfg.count_limit : count_up[COUNT_BITS-1:0];

   // Holdoff deadline wraps modulo the timer width.
   assign deadline = last_hit_ff + cfg.holdoff_time;
   assign expired  = timestamp > deadline;

   // Next state of the counters and the outputs of this beat.
   always_comb begin
      since_in    = since_inc;
      good_in     = good_ff;
      last_hit_in = last_hit_ff;
      period      = '0;
      detected    = 1'b0;
      if (crossing) begin
         period   = since_inc;
         since_in = '0;
         if (in_window) begin
            good_in = good_clamped;
            if (reach) begin
               detected    = expired;
               last_hit_in = timestamp;
            end
         end else if (good_ff != '0) begin
            good_in = good_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_centered_ff <= '0;
         since_ff         <= '0;
         good_ff          <= '0;
         last_hit_ff      <= '0;
      end else if (advance) begin
         prev_centered_ff <= centered;
         since_ff         <= since_in;
         good_ff          <= good_in;
         last_hit_ff      <= last_hit_in;
      end
   end

   assign result.centered    = centered;
   assign result.crossing    = crossing;
   assign result.period      = period;
   assign result.valid_count = good_in;
   assign result.detected    = detected;

endmodule

[rtl/zero_crossing_tone_detector_unit.sv]
// Top level of the zero crossing tone detector: window mean, stage registers and result register.
//
// The block takes one sample beat per clock cycle unless the result side stalls, and returns
// exactly one result beat for each, in order. A result beat passes through the first stage
// register and then the result register before it is offered. The first stage updates the
// 64-sample running sum from a ring held in a RAM with a registered read port, whose entry for
// the next position is read ahead; the second stage finds rising crossings, measures the period
// and updates the valid period count and the time of the last target hit. Ring entries not yet
// written since reset read as zero through one occupancy flag per entry, so no clearing pass is
// needed and samples are accepted as soon as reset is released. Registers may be written only
// while no beat is in flight.
module zero_crossing_tone_detector_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [ztd_pkg::SAMPLE_BITS-1:0]          req_sample,
   input  logic [ztd_pkg::TIME_BITS-1:0]            req_timestamp,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ztd_pkg::CENTERED_BITS-1:0] rsp_centered,
   output logic                                     rsp_crossing,
   output logic [ztd_pkg::PERIOD_BITS-1:0]          rsp_period,
   output logic [ztd_pkg::COUNT_BITS-1:0]           rsp_valid_count,
   output logic                                     rsp_detected,
   input  logic                                     csr_write,
   input  logic [ztd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ztd_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   import ztd_pkg::*;

   ztd_cfg_type cfg_ff;

   logic                    req_accept, out_advance, s1_advance;
   logic [POS_BITS-1:0]     pos_ff, pos_in, pos_inc;
   logic [WINDOW_DEPTH-1:0] filled_ff;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]  ram_rd_data, old_sample, mean;
   logic signed [CENTERED_BITS-1:0] centered;

   logic                            s1_valid_ff;
   logic signed [CENTERED_BITS-1:0] s1_centered_ff;
   logic [TIME_BITS-1:0]            s1_timestamp_ff;

   ztd_result_type detect_result;
   logic           rsp_valid_ff;
   ztd_result_type rsp_result_ff;

   // Handshake: each stage moves when the one after it is empty or moving.
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && out_advance;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign req_accept  = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_min   <= PERIOD_MIN_RESET;
         cfg_ff.period_max   <= PERIOD_MAX_RESET;
         cfg_ff.count_target <= COUNT_TARGET_RESET;
         cfg_ff.count_limit  <= COUNT_LIMIT_RESET;
         cfg_ff.holdoff_time <= HOLDOFF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PERIOD_MIN:   cfg_ff.period_min   <= csr_data[PERIOD_BITS-1:0];
            CSR_PERIOD_MAX:   cfg_ff.period_max   <= csr_data[PERIOD_BITS-1:0];
            CSR_COUNT_TARGET: cfg_ff.count_target <= csr_data[COUNT_BITS-1:0];
            CSR_COUNT_LIMIT:  cfg_ff.count_limit  <= csr_data[COUNT_BITS-1:0];
            CSR_HOLDOFF_TIME: cfg_ff.holdoff_time <= csr_data[TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Ring position; the RAM is read at the next position so its data is ready in time.
   assign pos_inc = (pos_ff == POS_BITS'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   always_comb begin
      if (reset) begin
         pos_in = '0;
      end else if (req_accept) begin
         pos_in = pos_inc;
      end else begin
         pos_in = pos_ff;
      end
   end

   ztd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (pos_ff),
      .wr_data (req_sample),
      .rd_addr (pos_in),
      .rd_data (ram_rd_data)
   );

   // An entry never written since reset counts as zero.
   assign old_sample = filled_ff[pos_ff] ? ram_rd_data : '0;

   // Running sum and mean-removed sample.
   assign sum_in   = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(req_sample);
   assign mean     = SAMPLE_BITS'(sum_in / WINDOW_DEPTH);
   assign centered = $signed({1'b0, req_sample}) - $signed({1'b0, mean});

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (reset) begin
         filled_ff <= '0;
         sum_ff    <= '0;
      end else if (req_accept) begin
         filled_ff[pos_ff] <= 1'b1;
         sum_ff            <= sum_in;
      end
   end

   // First stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         s1_centered_ff  <= centered;
         s1_timestamp_ff <= req_timestamp;
      end
   end

   ztd_detect u_detect (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_advance),
      .centered  (s1_centered_ff),
      .timestamp (s1_timestamp_ff),
      .cfg       (cfg_ff),
      .result    (detect_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_advance) begin
         rsp_result_ff <= detect_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centered    = rsp_result_ff.centered;
   assign rsp_crossing    = rsp_result_ff.crossing;
   assign rsp_period      = rsp_result_ff.period;
   assign rsp_valid_count = rsp_result_ff.valid_count;
   assign rsp_detected    = rsp_result_ff.detected;

endmodule

[rtl/ztd_checker.sv]
// Port-level checks of the zero crossing tone detector and their binding to the top level.
module ztd_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [ztd_pkg::CENTERED_BITS-1:0] rsp_centered,
   input logic                                     rsp_crossing,
   input logic [ztd_pkg::PERIOD_BITS-1:0]          rsp_period,
   input logic [ztd_pkg::COUNT_BITS-1:0]           rsp_valid_count,
   input logic                                     rsp_detected
);

   // No result beat is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_centered) &&
      $stable(rsp_crossing) && $stable(rsp_period) && $stable(rsp_valid_count) &&
      $stable(rsp_detected))
      else $error("stalled result beat changed");

   // A detection only happens on a crossing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |-> rsp_crossing)
      else $error("detection without crossing");

   // The period field is zero unless a crossing is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crossing |-> rsp_period == '0)
      else $error("period reported without crossing");

   // A rising crossing ends on a positive centered value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crossing |-> rsp_centered > 0)
      else $error("crossing on a non-positive sample");

endmodule

bind zero_crossing_tone_detector_unit ztd_checker u_ztd_checker (.*);
